@@ rtl/isrf_pkg.sv @@
// Package: shared types, constants and sequencer encodings for the inverse square root finder.
package isrf_pkg;

    localparam int unsigned DefMaxIterations = 1000;
    localparam int unsigned DefFractionBits  = 32;

    localparam logic signed [63:0] FX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] FX_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        CFG_FUNCTION = 2'd0,
        CFG_METHOD   = 2'd1,
        CFG_STOP     = 2'd2,
        CFG_LIMIT    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        STOP_COUNT    = 2'd0,
        STOP_ABSOLUTE = 2'd1,
        STOP_RELATIVE = 2'd2,
        STOP_SPARE    = 2'd3
    } stop_code_t;

    // Datapath operations: one per sequencer micro step.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } alu_op_t;

    // Register file slots.
    typedef enum logic [3:0] {
        R_ZERO, R_ONE, R_MTWO, R_ALPHA, R_PRIOR, R_CUR,
        R_T0, R_T1, R_T2, R_T3, R_T4, R_ANS
    } reg_sel_t;

    typedef struct packed {
        logic     start;
        alu_op_t  op;
        reg_sel_t src_a;
        reg_sel_t src_b;
        reg_sel_t dst;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
        logic estimates_equal;
        logic err_ge_limit;
    } dp_status_t;

    typedef enum logic [5:0] {
        S_IDLE,
        // answer of current
        S_ANS_DIV, S_ANS_WAIT,
        // stop test
        S_TST_ANS, S_TST_MUL, S_TST_DIV, S_TST_SUB, S_TST_REL, S_TST_CHK,
        // Newton
        S_NW_SQ, S_NW_G0, S_NW_G1, S_NW_D0, S_NW_D1, S_NW_D2, S_NW_D3,
        S_NW_Q, S_NW_X,
        // secant: g(cur) -> T3, g(prior) -> T4
        S_SC_CHK, S_SC_SQC, S_SC_GC0, S_SC_GC1, S_SC_SQP, S_SC_GP0, S_SC_GP1,
        S_SC_DX, S_SC_DG, S_SC_Q, S_SC_M, S_SC_X,
        S_STEP_DONE,
        S_OUT_ANS, S_OUT
    } state_t;

endpackage

@@ rtl/inverse_sqrt_root_finder.sv @@
// Top level: stream ports, configuration registers, controller and datapath.
//
// Computes 1/sqrt(alpha) in signed Q32.32 by Newton or secant iteration, one item at a
// time. Each step runs on one shared datapath: a saturating adder, a 64x64 multiplier
// (four 32x32 partial products, then the write) and a restoring divider that yields
// one quotient bit per cycle. The stop test runs before every step and once more at
// the end; by count on x^2-alpha it includes the 1/x division, and an absolute or a
// relative error test adds a multiply and further divisions.
// The result is held in an output register until taken; no reset clearing pass is needed.
module inverse_sqrt_root_finder
    import isrf_pkg::*;
#(
    parameter int unsigned MAX_ITERATIONS = DefMaxIterations,
    parameter int unsigned FRACTION_BITS  = DefFractionBits
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // alpha[62:0], first_guess[126:63], second_guess[190:127]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,   // root_result[63:0], iterations_used[73:64],
                                    // not_converged[74], divide_fault[75]
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [62:0]  cfg_data
);

    logic        function_choice_reg, method_choice_reg;
    stop_code_t  stop_criterion_reg;
    logic [62:0] stop_limit_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            function_choice_reg <= 1'b0;
            method_choice_reg   <= 1'b0;
            stop_criterion_reg  <= STOP_COUNT;
            stop_limit_reg      <= 63'd42949672960;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_FUNCTION: function_choice_reg <= cfg_data[0];
                CFG_METHOD:   method_choice_reg   <= cfg_data[0];
                CFG_STOP:     stop_criterion_reg  <= stop_code_t'(cfg_data[1:0]);
                CFG_LIMIT:    stop_limit_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    logic        s_fire, m_free, load, store_pc, done, capped, idle, fault;
    logic [15:0] count;
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic signed [63:0] answer;

    logic        m_valid_reg;
    logic [79:0] m_data_reg;

    assign s_tready = idle && aresetn;
    assign s_fire   = s_tvalid && s_tready;
    assign m_free   = !m_valid_reg || m_tready;

    isrf_control #(.MAX_ITERATIONS(MAX_ITERATIONS), .FRACTION_BITS(FRACTION_BITS)) u_ctrl (
        .aclk, .aresetn, .s_fire, .m_free,
        .function_choice(function_choice_reg), .method_choice(method_choice_reg),
        .stop_criterion(stop_criterion_reg), .stop_limit(stop_limit_reg),
        .status, .load, .store_prior_cur(store_pc), .done, .capped, .count, .cmd, .idle
    );

    isrf_datapath #(.FRACTION_BITS(FRACTION_BITS)) u_dp (
        .aclk, .aresetn, .load,
        .alpha(s_tdata[62:0]), .first_guess(s_tdata[126:63]),
        .second_guess(s_tdata[190:127]), .stop_limit(stop_limit_reg),
        .store_prior_cur(store_pc), .cmd, .status, .fault, .answer
    );

    // Hold result until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if (done && m_free) begin
                m_valid_reg <= 1'b1;
                m_data_reg  <= {4'd0, fault, capped, count[9:0],
                                capped ? 64'd0 : answer};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Input is taken only while the sequencer is idle
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !idle)
        else $error("accepted item did not start sequencer");
    // A result appears only when the sequencer finishes
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(done))
        else $error("result without completion");
    // Count never passes the cap
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count) <= MAX_ITERATIONS)
        else $error("iteration count beyond cap");

endmodule

@@ rtl/isrf_datapath.sv @@
// Datapath: register file, saturating add/sub, multi cycle multiplier and restoring divider.
module isrf_datapath
    import isrf_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = DefFractionBits
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic [62:0]        alpha,
    input  logic signed [63:0] first_guess,
    input  logic signed [63:0] second_guess,
    input  logic [62:0]        stop_limit,
    input  logic               store_prior_cur,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic               fault,
    output logic signed [63:0] answer
);

    localparam logic signed [63:0] FxOne  = 64'sd1 <<< FRACTION_BITS;
    localparam logic signed [63:0] FxMTwo = -(64'sd2 <<< FRACTION_BITS);

    logic signed [63:0] rf_reg [12];
    logic signed [63:0] a_val, b_val;
    logic               fault_reg;

    // Operand read
    always_comb begin
        case (cmd.src_a)
            R_ZERO:  a_val = '0;
            R_ONE:   a_val = FxOne;
            R_MTWO:  a_val = FxMTwo;
            default: a_val = rf_reg[cmd.src_a];
        endcase
        case (cmd.src_b)
            R_ZERO:  b_val = '0;
            R_ONE:   b_val = FxOne;
            R_MTWO:  b_val = FxMTwo;
            default: b_val = rf_reg[cmd.src_b];
        endcase
    end

    // Saturating add and subtract
    logic signed [64:0] sum_w, dif_w;
    logic signed [63:0] sum_sat, dif_sat;
    assign sum_w = {a_val[63], a_val} + {b_val[63], b_val};
    assign dif_w = {a_val[63], a_val} - {b_val[63], b_val};
    always_comb begin
        sum_sat = (sum_w[64] != sum_w[63]) ? (sum_w[64] ? FX_MIN : FX_MAX) : sum_w[63:0];
        dif_sat = (dif_w[64] != dif_w[63]) ? (dif_w[64] ? FX_MIN : FX_MAX) : dif_w[63:0];
    end

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        mag_of = v[63] ? 64'(-v) : v;
    endfunction

    function automatic logic signed [63:0] from_mag(input logic neg, input logic big,
                                                     input logic [63:0] m);
        logic signed [63:0] r;
        if (!neg) begin
            r = (big || m[63]) ? FX_MAX : m;
        end else begin
            r = (big || m[63]) ? FX_MIN : 64'(-m);
        end
        from_mag = r;
    endfunction

    // Multiply: four 32x32 partial products, one per cycle
    logic [63:0]  mx_reg, my_reg;
    logic [127:0] macc_reg;
    logic [2:0]   mcnt_reg;
    logic         mneg_reg, mbusy_reg;
    logic [63:0]  pp;
    logic [127:0] pp_shift;
    logic [1:0]   pp_sel;
    assign pp_sel = mcnt_reg[1:0];
    always_comb begin
        pp = {32'd0, mx_reg[pp_sel[0]*32 +: 32]} * {32'd0, my_reg[pp_sel[1]*32 +: 32]};
        pp_shift = {64'd0, pp} << (7'(pp_sel[0]) * 7'd32 + 7'(pp_sel[1]) * 7'd32);
    end
    logic [63:0]  mq;
    logic         mbig;
    assign mq   = 64'(macc_reg >> FRACTION_BITS);
    assign mbig = |(macc_reg >> (64 + FRACTION_BITS));

    // Divide: restoring, one quotient bit a cycle over 128 bits
    logic [127:0] dn_reg;
    logic [63:0]  dd_reg, rem_reg;
    logic [127:0] dq_reg;
    logic [7:0]   dcnt_reg;
    logic         dneg_reg, dbusy_reg;
    logic [64:0]  rem_sh;
    logic [64:0]  rem_try;
    assign rem_sh  = {rem_reg, dn_reg[127]};
    assign rem_try = rem_sh - {1'b0, dd_reg};

    reg_sel_t pend_dst_reg;
    logic     start;
    assign start = cmd.start;

    // Sequence register file, multiplier and divider
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            fault_reg <= 1'b0;
        end else begin
            if (load) begin
                rf_reg[R_ALPHA] <= {1'b0, alpha};
                rf_reg[R_PRIOR] <= first_guess;
                rf_reg[R_CUR]   <= second_guess;
                fault_reg       <= 1'b0;
            end
            if (store_prior_cur) begin
                rf_reg[R_PRIOR] <= rf_reg[R_CUR];
                rf_reg[R_CUR]   <= rf_reg[R_T0];
            end
            if (start) begin
                pend_dst_reg <= cmd.dst;
                case (cmd.op)
                    OP_ADD: rf_reg[cmd.dst] <= sum_sat;
                    OP_SUB: rf_reg[cmd.dst] <= dif_sat;
                    OP_MUL: begin
                        mx_reg    <= mag_of(a_val);
                        my_reg    <= mag_of(b_val);
                        mneg_reg  <= a_val[63] ^ b_val[63];
                        macc_reg  <= '0;
                        mcnt_reg  <= '0;
                        mbusy_reg <= 1'b1;
                    end
                    OP_DIV: begin
                        if (b_val == '0) begin
                            fault_reg       <= 1'b1;
                            rf_reg[cmd.dst] <= a_val[63] ? FX_MIN : FX_MAX;
                        end else begin
                            dn_reg    <= {64'd0, mag_of(a_val)} << FRACTION_BITS;
                            dd_reg    <= mag_of(b_val);
                            rem_reg   <= '0;
                            dq_reg    <= '0;
                            dcnt_reg  <= '0;
                            dneg_reg  <= a_val[63] ^ b_val[63];
                            dbusy_reg <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (mbusy_reg) begin
                if (mcnt_reg[2]) begin
                    rf_reg[pend_dst_reg] <= from_mag(mneg_reg, mbig, mq);
                    mbusy_reg <= 1'b0;
                end else begin
                    macc_reg <= macc_reg + pp_shift;
                    mcnt_reg <= mcnt_reg + 3'd1;
                end
            end
            if (dbusy_reg) begin
                if (dcnt_reg[7]) begin
                    rf_reg[pend_dst_reg] <= from_mag(dneg_reg, |dq_reg[127:64], dq_reg[63:0]);
                    dbusy_reg <= 1'b0;
                end else begin
                    dn_reg   <= dn_reg << 1;
                    dcnt_reg <= dcnt_reg + 8'd1;
                    if (!rem_try[64]) begin
                        rem_reg <= rem_try[63:0];
                        dq_reg  <= {dq_reg[126:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[63:0];
                        dq_reg  <= {dq_reg[126:0], 1'b0};
                    end
                end
            end
        end
    end

    assign status.busy            = mbusy_reg | dbusy_reg;
    assign status.estimates_equal = (rf_reg[R_CUR] == rf_reg[R_PRIOR]);
    assign status.err_ge_limit    = (mag_of(rf_reg[R_T0]) >= {1'b0, stop_limit});
    assign fault  = fault_reg;
    assign answer = rf_reg[R_ANS];

endmodule

@@ rtl/isrf_control.sv @@
// Controller: sequences stop test, Newton or secant steps and result hand-off.
module isrf_control
    import isrf_pkg::*;
#(
    parameter int unsigned MAX_ITERATIONS = DefMaxIterations,
    parameter int unsigned FRACTION_BITS  = DefFractionBits
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_fire,
    input  logic        m_free,
    input  logic        function_choice,
    input  logic        method_choice,
    input  stop_code_t  stop_criterion,
    input  logic [62:0] stop_limit,
    input  dp_status_t  status,
    output logic        load,
    output logic        store_prior_cur,
    output logic        done,
    output logic        capped,
    output logic [15:0] count,
    output dp_cmd_t     cmd,
    output logic        idle
);

    localparam int CW = $clog2(MAX_ITERATIONS + 1);

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          fn;
    logic          by_error;
    logic          count_go;
    logic [63+CW:0] cnt_fx;

    assign fn       = function_choice;
    assign by_error = (stop_criterion == STOP_ABSOLUTE) || (stop_criterion == STOP_RELATIVE);
    assign cnt_fx   = {64'd0, cnt_reg} << FRACTION_BITS;
    assign count_go = cnt_fx < {{(CW+1){1'b0}}, stop_limit};

    // Advance state and iteration counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    logic keep;
    assign keep = (by_error ? status.err_ge_limit : count_go)
                  && (32'(cnt_reg) < MAX_ITERATIONS);

    // Next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        if (status.busy) begin
            state_next = state_reg;
        end else begin
            case (state_reg)
                S_IDLE:     if (s_fire) begin
                    state_next = S_TST_ANS;
                    cnt_next   = '0;
                end
                S_TST_ANS:  state_next = by_error ? S_TST_MUL : S_TST_CHK;
                S_TST_MUL:  state_next = S_TST_DIV;
                S_TST_DIV:  state_next = S_TST_SUB;
                S_TST_SUB:  state_next = (stop_criterion == STOP_RELATIVE) ? S_TST_REL : S_TST_CHK;
                S_TST_REL:  state_next = S_TST_CHK;
                S_TST_CHK:  state_next = keep ? (method_choice ? S_SC_CHK : S_NW_SQ)
                                              : (fn ? S_OUT : S_ANS_DIV);
                S_NW_SQ:    state_next = S_NW_G0;
                S_NW_G0:    state_next = fn ? S_NW_G1 : S_NW_D0;
                S_NW_G1:    state_next = S_NW_D0;
                S_NW_D0:    state_next = fn ? S_NW_D1 : S_NW_Q;
                S_NW_D1:    state_next = S_NW_D2;
                S_NW_D2:    state_next = S_NW_Q;
                S_NW_Q:     state_next = S_NW_X;
                S_NW_X:     state_next = S_STEP_DONE;
                S_SC_CHK:   state_next = status.estimates_equal ? S_STEP_DONE : S_SC_SQC;
                S_SC_SQC:   state_next = S_SC_GC0;
                S_SC_GC0:   state_next = fn ? S_SC_GC1 : S_SC_SQP;
                S_SC_GC1:   state_next = S_SC_SQP;
                S_SC_SQP:   state_next = S_SC_GP0;
                S_SC_GP0:   state_next = fn ? S_SC_GP1 : S_SC_DX;
                S_SC_GP1:   state_next = S_SC_DX;
                S_SC_DX:    state_next = S_SC_DG;
                S_SC_DG:    state_next = S_SC_Q;
                S_SC_Q:     state_next = S_SC_M;
                S_SC_M:     state_next = S_SC_X;
                S_SC_X:     state_next = S_STEP_DONE;
                S_STEP_DONE: begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = S_TST_ANS;
                end
                S_ANS_DIV:  state_next = S_ANS_WAIT;
                S_ANS_WAIT: state_next = S_OUT;
                S_OUT:      if (m_free) state_next = S_IDLE;
                default:    state_next = S_IDLE;
            endcase
        end
    end

    // Commands. Test and answer work on ANS (= 1/cur or cur) via T0.
    always_comb begin
        cmd             = '{start: 1'b0, op: OP_ADD, src_a: R_ZERO, src_b: R_ZERO, dst: R_T0};
        load            = 1'b0;
        store_prior_cur = 1'b0;
        done            = 1'b0;
        if (!status.busy) begin
            case (state_reg)
                S_IDLE:    load = s_fire;
                // ANS <- answer of current, then err into T0
                S_TST_ANS: cmd = fn ? '{1'b1, OP_ADD, R_CUR, R_ZERO, R_ANS}
                                    : '{1'b1, OP_DIV, R_ONE, R_CUR, R_ANS};
                S_TST_MUL: cmd = '{1'b1, OP_MUL, R_ANS, R_ANS, R_T0};
                S_TST_DIV: cmd = '{1'b1, OP_DIV, R_ONE, R_T0, R_T0};
                S_TST_SUB: cmd = '{1'b1, OP_SUB, R_T0, R_ALPHA, R_T0};
                S_TST_REL: cmd = '{1'b1, OP_DIV, R_T0, R_ALPHA, R_T0};
                // Newton on prior: T1 = g(x), T2 = g'(x)
                S_NW_SQ:   cmd = '{1'b1, OP_MUL, R_PRIOR, R_PRIOR, R_T1};
                S_NW_G0:   cmd = fn ? '{1'b1, OP_DIV, R_ONE, R_T1, R_T3}
                                    : '{1'b1, OP_SUB, R_T1, R_ALPHA, R_T1};
                S_NW_G1:   cmd = '{1'b1, OP_SUB, R_T3, R_ALPHA, R_T1};
                S_NW_D0:   cmd = fn ? '{1'b1, OP_MUL, R_PRIOR, R_PRIOR, R_T2}
                                    : '{1'b1, OP_ADD, R_PRIOR, R_PRIOR, R_T2};
                S_NW_D1:   cmd = '{1'b1, OP_MUL, R_T2, R_PRIOR, R_T2};
                S_NW_D2:   cmd = '{1'b1, OP_DIV, R_MTWO, R_T2, R_T2};
                S_NW_Q:    cmd = '{1'b1, OP_DIV, R_T1, R_T2, R_T1};
                S_NW_X:    cmd = '{1'b1, OP_SUB, R_PRIOR, R_T1, R_PRIOR};
                // Secant
                S_SC_SQC:  cmd = '{1'b1, OP_MUL, R_CUR, R_CUR, R_T3};
                S_SC_GC0:  cmd = fn ? '{1'b1, OP_DIV, R_ONE, R_T3, R_T3}
                                    : '{1'b1, OP_SUB, R_T3, R_ALPHA, R_T3};
                S_SC_GC1:  cmd = '{1'b1, OP_SUB, R_T3, R_ALPHA, R_T3};
                S_SC_SQP:  cmd = '{1'b1, OP_MUL, R_PRIOR, R_PRIOR, R_T4};
                S_SC_GP0:  cmd = fn ? '{1'b1, OP_DIV, R_ONE, R_T4, R_T4}
                                    : '{1'b1, OP_SUB, R_T4, R_ALPHA, R_T4};
                S_SC_GP1:  cmd = '{1'b1, OP_SUB, R_T4, R_ALPHA, R_T4};
                S_SC_DX:   cmd = '{1'b1, OP_SUB, R_CUR, R_PRIOR, R_T1};
                S_SC_DG:   cmd = '{1'b1, OP_SUB, R_T3, R_T4, R_T2};
                S_SC_Q:    cmd = '{1'b1, OP_DIV, R_T1, R_T2, R_T1};
                S_SC_M:    cmd = '{1'b1, OP_MUL, R_T1, R_T3, R_T1};
                S_SC_X:    cmd = '{1'b1, OP_SUB, R_CUR, R_T1, R_T0};
                S_STEP_DONE: begin
                    // Newton leaves the new estimate in prior; mirror into cur.
                    // Secant shifts the estimates unless they were equal (hold).
                    if (method_choice) begin
                        store_prior_cur = !status.estimates_equal;
                    end else begin
                        cmd = '{1'b1, OP_ADD, R_PRIOR, R_ZERO, R_CUR};
                    end
                end
                S_ANS_DIV: cmd = '{1'b1, OP_DIV, R_ONE, R_CUR, R_ANS};
                S_OUT:     done = 1'b1;
                default:   ;
            endcase
        end
    end

    assign capped = !(32'(cnt_reg) < MAX_ITERATIONS);
    assign count  = 16'(cnt_reg);
    assign idle   = (state_reg == S_IDLE);

endmodule
